// ----- rtl/afs_pkg.sv -----
// ----------------------------------------------------------------------------
// afs_pkg: shared types and constants of the audio frame statistics unit
// Sample format, default frame limit, level meter scaling and result record.
// ----------------------------------------------------------------------------
package afs_pkg;

   localparam int AFS_SAMPLE_W   = 16;
   localparam int AFS_MAX_FRAME  = 256;
   localparam int AFS_FULL_SCALE = 32768;
   localparam int AFS_LEVEL_MAX  = 32;
   localparam int AFS_LEVEL_W    = 6;
   localparam int AFS_LEVEL_SHIFT = $clog2(AFS_FULL_SCALE / AFS_LEVEL_MAX);
   // radicand of the rms root is at most full scale squared
   localparam int AFS_ROOT_STEPS = 16;
   localparam int AFS_RAD_W      = 2 * AFS_ROOT_STEPS;
   localparam int AFS_ROOT_REM_W = AFS_ROOT_STEPS + 1;

   localparam logic signed [AFS_SAMPLE_W-1:0] AFS_MIN_RESET = 16'sh7fff;
   localparam logic signed [AFS_SAMPLE_W-1:0] AFS_MAX_RESET = 16'sh8000;

   typedef struct packed {
      logic signed [AFS_SAMPLE_W-1:0] frame_min;
      logic signed [AFS_SAMPLE_W-1:0] frame_max;
      logic signed [AFS_SAMPLE_W-1:0] frame_mean;
      logic [AFS_SAMPLE_W-1:0]        frame_rms;
      logic [AFS_LEVEL_W-1:0]         level_meter;
   } afs_result_type;

endpackage

// ----- rtl/afs_accum.sv -----
// ----------------------------------------------------------------------------
// afs_accum: running frame accumulators
// Keeps minimum, maximum, sum, sum of squares and count, one accepted beat a
// cycle, and hands the closing totals to the sequencer when a frame ends.
// ----------------------------------------------------------------------------
module afs_accum import afs_pkg::*; #(
   parameter int MAX_FRAME = AFS_MAX_FRAME,
   parameter int CW        = $clog2(MAX_FRAME + 1),
   parameter int SW        = CW + 16,
   parameter int QW        = CW + 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic signed [AFS_SAMPLE_W-1:0] sample,
   input  logic                           frame_end,
   output logic                           close,
   output logic signed [AFS_SAMPLE_W-1:0] tot_min,
   output logic signed [AFS_SAMPLE_W-1:0] tot_max,
   output logic signed [SW-1:0]           tot_sum,
   output logic [QW-1:0]                  tot_sumsq,
   output logic [CW-1:0]                  tot_cnt
);

   logic signed [AFS_SAMPLE_W-1:0]   min_ff, max_ff;
   logic signed [SW-1:0]             sum_ff;
   logic [QW-1:0]                    sumsq_ff;
   logic [CW-1:0]                    cnt_ff;
   logic signed [2*AFS_SAMPLE_W-1:0] square;
   logic                             last;

   always_comb begin
      square    = sample * sample;
      tot_min   = (sample < min_ff) ? sample : min_ff;
      tot_max   = (sample > max_ff) ? sample : max_ff;
      tot_sum   = sum_ff + SW'(sample);
      tot_sumsq = sumsq_ff + QW'(unsigned'(square));
      tot_cnt   = cnt_ff + 1'b1;
      last      = frame_end || (tot_cnt == CW'(MAX_FRAME));
      close     = accept && last;
   end

   always_ff @(posedge clock) begin
      if (reset || close) begin
         min_ff   <= AFS_MIN_RESET;
         max_ff   <= AFS_MAX_RESET;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         cnt_ff   <= '0;
      end else if (accept) begin
         min_ff   <= tot_min;
         max_ff   <= tot_max;
         sum_ff   <= tot_sum;
         sumsq_ff <= tot_sumsq;
         cnt_ff   <= tot_cnt;
      end
   end

endmodule

// ----- rtl/afs_sub_unit.sv -----
// ----------------------------------------------------------------------------
// afs_sub_unit: shared subtract and compare
// One trial subtraction per cycle for both long division and the root.
// ----------------------------------------------------------------------------
module afs_sub_unit #(
   parameter int WIDTH = 19
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] diff,
   output logic             ge
);

   logic [WIDTH:0] wide;

   always_comb begin
      wide = {1'b0, a} - {1'b0, b};
      ge   = ~wide[WIDTH];
      diff = wide[WIDTH-1:0];
   end

endmodule

// ----- rtl/afs_seq.sv -----
// ----------------------------------------------------------------------------
// afs_seq: end-of-frame sequencer
// Runs the mean division, the mean-square division and the integer square
// root one bit per cycle on the shared subtractor, then loads the result
// register.
// ----------------------------------------------------------------------------
module afs_seq import afs_pkg::*; #(
   parameter int MAX_FRAME = AFS_MAX_FRAME,
   parameter int CW        = $clog2(MAX_FRAME + 1),
   parameter int SW        = CW + 16,
   parameter int QW        = CW + 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [AFS_SAMPLE_W-1:0] tot_min,
   input  logic signed [AFS_SAMPLE_W-1:0] tot_max,
   input  logic signed [SW-1:0]           tot_sum,
   input  logic [QW-1:0]                  tot_sumsq,
   input  logic [CW-1:0]                  tot_cnt,
   input  logic                           rsp_stall,
   output logic                           busy,
   output logic                           rsp_valid,
   output afs_result_type                 result
);

   localparam int RW   = (CW > AFS_ROOT_REM_W) ? CW : AFS_ROOT_REM_W;
   localparam int SUBW = (CW + 1 > AFS_ROOT_REM_W + 2) ? CW + 1 : AFS_ROOT_REM_W + 2;
   localparam int IW   = $clog2(QW + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MEAN = 5'b00010,
      ST_MSQ  = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic signed [AFS_SAMPLE_W-1:0] min_ff, max_ff, mean_ff;
   logic [AFS_SAMPLE_W-1:0]        rms_ff, root_ff, root_nxt;
   logic                           neg_ff;
   logic [QW-1:0]                  dvd_ff, sq_ff, quo_ff, quo_nxt;
   logic [CW-1:0]                  div_ff;
   logic [RW-1:0]                  rem_ff;
   logic [IW-1:0]                  iter_ff;
   logic [SUBW-1:0]                sub_a, sub_b, sub_diff;
   logic                           sub_ge;
   logic [SUBW-1:0]                rem_pick;
   logic [SW-1:0]                  abs_sum;
   logic [AFS_SAMPLE_W-1:0]        mean_mag;
   logic [AFS_LEVEL_W-1:0]         bars;
   logic                           rsp_valid_ff;
   afs_result_type                 result_ff;
   logic                           load_out;

   afs_sub_unit #(.WIDTH(SUBW)) u_sub (
      .a    (sub_a),
      .b    (sub_b),
      .diff (sub_diff),
      .ge   (sub_ge)
   );

   always_comb begin
      if (state_ff == ST_ROOT) begin
         sub_a = SUBW'({rem_ff[AFS_ROOT_REM_W-1:0], dvd_ff[QW-1:QW-2]});
         sub_b = SUBW'({root_ff, 2'b01});
      end else begin
         sub_a = SUBW'({rem_ff[CW-1:0], dvd_ff[QW-1]});
         sub_b = SUBW'(div_ff);
      end
      rem_pick = sub_ge ? sub_diff : sub_a;
      quo_nxt  = {quo_ff[QW-2:0], sub_ge};
      root_nxt = {root_ff[AFS_SAMPLE_W-2:0], sub_ge};
      abs_sum  = tot_sum[SW-1] ? SW'(-tot_sum) : SW'(tot_sum);
      mean_mag = quo_nxt[AFS_SAMPLE_W-1:0];
      bars     = AFS_LEVEL_W'(rms_ff >> AFS_LEVEL_SHIFT);
      if (bars > AFS_LEVEL_W'(AFS_LEVEL_MAX)) begin
         bars = AFS_LEVEL_W'(AFS_LEVEL_MAX);
      end
      load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_MEAN;
         ST_MEAN: if (iter_ff == '0) state_in = ST_MSQ;
         ST_MSQ:  if (iter_ff == '0) state_in = ST_ROOT;
         ST_ROOT: if (iter_ff == '0) state_in = ST_DONE;
         ST_DONE: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               min_ff  <= tot_min;
               max_ff  <= tot_max;
               neg_ff  <= tot_sum[SW-1];
               dvd_ff  <= QW'(abs_sum) << (QW - SW);
               sq_ff   <= tot_sumsq;
               div_ff  <= tot_cnt;
               rem_ff  <= '0;
               quo_ff  <= '0;
               iter_ff <= IW'(SW - 1);
            end
         end
         ST_MEAN: begin
            if (iter_ff == '0) begin
               mean_ff <= neg_ff ? -signed'(mean_mag) : signed'(mean_mag);
               dvd_ff  <= sq_ff;
               rem_ff  <= '0;
               quo_ff  <= '0;
               iter_ff <= IW'(QW - 1);
            end else begin
               dvd_ff  <= dvd_ff << 1;
               rem_ff  <= RW'(rem_pick);
               quo_ff  <= quo_nxt;
               iter_ff <= iter_ff - 1'b1;
            end
         end
         ST_MSQ: begin
            if (iter_ff == '0) begin
               dvd_ff  <= QW'(quo_nxt[AFS_RAD_W-1:0]) << (QW - AFS_RAD_W);
               rem_ff  <= '0;
               root_ff <= '0;
               iter_ff <= IW'(AFS_ROOT_STEPS - 1);
            end else begin
               dvd_ff  <= dvd_ff << 1;
               rem_ff  <= RW'(rem_pick);
               quo_ff  <= quo_nxt;
               iter_ff <= iter_ff - 1'b1;
            end
         end
         ST_ROOT: begin
            dvd_ff  <= dvd_ff << 2;
            rem_ff  <= RW'(rem_pick);
            root_ff <= root_nxt;
            iter_ff <= iter_ff - 1'b1;
            if (iter_ff == '0) begin
               rms_ff <= root_nxt;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               result_ff.frame_min   <= min_ff;
               result_ff.frame_max   <= max_ff;
               result_ff.frame_mean  <= mean_ff;
               result_ff.frame_rms   <= rms_ff;
               result_ff.level_meter <= bars;
            end
         end
         default: ;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

// ----- rtl/audio_frame_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// audio_frame_statistics_unit: per-frame min, max, mean, rms and level meter
// Input channel req_*: one signed sample a beat plus a frame end flag.
// Samples are taken one a cycle while a frame runs and req_stall is low;
// a frame also closes by force once MAX_FRAME samples are in.
// On the closing beat the totals go to the sequencer and the accumulators
// clear. req_stall then stays high while the mean division, the
// mean-square division and the 16-step root run on one shared subtractor,
// and until the result register is loaded.
// Result channel rsp_*: one beat a frame, held in an output register; new
// samples are taken while it waits. A result that finds the register still
// held under rsp_stall waits in the sequencer, stalling the input.
// Reset (synchronous, active high) empties the frame and drops rsp_valid.
// ----------------------------------------------------------------------------
module audio_frame_statistics_unit import afs_pkg::*; #(
   parameter int MAX_FRAME = AFS_MAX_FRAME
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [AFS_SAMPLE_W-1:0] req_sample,
   input  logic                           req_frame_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [AFS_SAMPLE_W-1:0] rsp_frame_min,
   output logic signed [AFS_SAMPLE_W-1:0] rsp_frame_max,
   output logic signed [AFS_SAMPLE_W-1:0] rsp_frame_mean,
   output logic [AFS_SAMPLE_W-1:0]        rsp_frame_rms,
   output logic [AFS_LEVEL_W-1:0]         rsp_level_meter
);

   localparam int CW = $clog2(MAX_FRAME + 1);
   localparam int SW = CW + 16;
   localparam int QW = CW + 31;

   logic                           accept, close, busy;
   logic signed [AFS_SAMPLE_W-1:0] tot_min, tot_max;
   logic signed [SW-1:0]           tot_sum;
   logic [QW-1:0]                  tot_sumsq;
   logic [CW-1:0]                  tot_cnt;
   afs_result_type                 result;

   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   afs_accum #(.MAX_FRAME(MAX_FRAME), .CW(CW), .SW(SW), .QW(QW)) u_accum (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .sample    (req_sample),
      .frame_end (req_frame_end),
      .close     (close),
      .tot_min   (tot_min),
      .tot_max   (tot_max),
      .tot_sum   (tot_sum),
      .tot_sumsq (tot_sumsq),
      .tot_cnt   (tot_cnt)
   );

   afs_seq #(.MAX_FRAME(MAX_FRAME), .CW(CW), .SW(SW), .QW(QW)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (close),
      .tot_min   (tot_min),
      .tot_max   (tot_max),
      .tot_sum   (tot_sum),
      .tot_sumsq (tot_sumsq),
      .tot_cnt   (tot_cnt),
      .rsp_stall (rsp_stall),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .result    (result)
   );

   assign rsp_frame_min   = result.frame_min;
   assign rsp_frame_max   = result.frame_max;
   assign rsp_frame_mean  = result.frame_mean;
   assign rsp_frame_rms   = result.frame_rms;
   assign rsp_level_meter = result.level_meter;

   // a closing beat starts the sequencer, which then holds off the input
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      close |=> busy)
      else $error("frame close did not start the sequencer");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_min <= rsp_frame_max))
      else $error("frame minimum above maximum");

   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_mean >= rsp_frame_min && rsp_frame_mean <= rsp_frame_max))
      else $error("frame mean outside minimum and maximum");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level_meter <= AFS_LEVEL_W'(AFS_LEVEL_MAX)))
      else $error("level meter above full scale");

endmodule
